[hw/rtl/i8080_branch_call_return_unit_macros.svh]
// Assertion macros shared by the control-transfer unit
`ifndef I8080_BRANCH_CALL_RETURN_UNIT_MACROS_SVH
`define I8080_BRANCH_CALL_RETURN_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset
`define BCRU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included
`define BCRU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCRU_ASSERT(label, clk, rst_n, prop, msg)
`define BCRU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[hw/rtl/bcru_pkg.sv]
package bcru_pkg;

  localparam int unsigned STACK_ADDR_BITS_DEF = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned CYC_W  = 5;

  // Opcodes and opcode-group masks
  localparam logic [7:0] OP_JMP      = 8'hC3;
  localparam logic [7:0] OP_CALL     = 8'hCD;
  localparam logic [7:0] OP_RET      = 8'hC9;
  localparam logic [7:0] OP_GRP_MASK = 8'hC7;
  localparam logic [7:0] OP_GRP_JCC  = 8'hC2;
  localparam logic [7:0] OP_GRP_CCC  = 8'hC4;
  localparam logic [7:0] OP_GRP_RCC  = 8'hC0;

  // Condition flag selectors (opcode bits 5:4)
  localparam logic [1:0] COND_Z = 2'd0;
  localparam logic [1:0] COND_C = 2'd1;
  localparam logic [1:0] COND_P = 2'd2;
  localparam logic [1:0] COND_S = 2'd3;

  // Machine cycle counts
  localparam logic [CYC_W-1:0] CYC_NONE      = 5'd0;
  localparam logic [CYC_W-1:0] CYC_JUMP      = 5'd10;
  localparam logic [CYC_W-1:0] CYC_CALL_TKN  = 5'd17;
  localparam logic [CYC_W-1:0] CYC_CALL_NTKN = 5'd11;
  localparam logic [CYC_W-1:0] CYC_RET       = 5'd10;
  localparam logic [CYC_W-1:0] CYC_RCC_TKN   = 5'd11;
  localparam logic [CYC_W-1:0] CYC_RCC_NTKN  = 5'd5;

  localparam logic [ADDR_W-1:0] PC_STEP_LONG  = 16'd3;
  localparam logic [ADDR_W-1:0] PC_STEP_SHORT = 16'd1;
  localparam logic [ADDR_W-1:0] SP_STEP_ONE   = 16'd1;
  localparam logic [ADDR_W-1:0] SP_STEP_TWO   = 16'd2;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_LOAD = 3'd1,
    KIND_JUMP = 3'd2,
    KIND_CALL = 3'd3,
    KIND_RET  = 3'd4
  } bcru_kind_e;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        opcode;
    logic [7:0]        target_low;
    logic [7:0]        target_high;
    logic [7:0]        flag_byte;
    logic [ADDR_W-1:0] load_pc;
    logic [ADDR_W-1:0] load_sp;
  } bcru_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic [ADDR_W-1:0] next_sp;
    logic              taken;
    logic [CYC_W-1:0]  cycle_count;
    logic              recognized;
  } bcru_out_t;

  typedef struct packed {
    bcru_kind_e       kind;
    logic             taken;
    logic [CYC_W-1:0] cycles;
    logic             recognized;
  } bcru_dec_t;

  // Sequencer status towards the top level
  typedef struct packed {
    logic      ready;
    logic      done;
    bcru_out_t result;
  } bcru_ctrl_t;

endpackage

[hw/rtl/bcru_ram.sv]
module bcru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port: write, or registered read that holds until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bcru_decode.sv]
module bcru_decode (
  input  bcru_pkg::bcru_in_t  item_i,
  output bcru_pkg::bcru_dec_t dec_o
);
  import bcru_pkg::*;

  logic [7:0] op;
  logic       flag_bit;
  logic       cond;
  logic       is_jump;
  logic       is_call;
  logic       is_ret;

  assign op = item_i.opcode;

  // Pick the condition flag and apply the polarity bit
  always_comb begin
    case (op[5:4])
      COND_Z:  flag_bit = item_i.flag_byte[6];
      COND_C:  flag_bit = item_i.flag_byte[0];
      COND_P:  flag_bit = item_i.flag_byte[2];
      COND_S:  flag_bit = item_i.flag_byte[7];
      default: flag_bit = 1'b0;
    endcase
  end

  assign cond    = op[3] ? flag_bit : !flag_bit;
  assign is_jump = (op == OP_JMP)  || ((op & OP_GRP_MASK) == OP_GRP_JCC);
  assign is_call = (op == OP_CALL) || ((op & OP_GRP_MASK) == OP_GRP_CCC);
  assign is_ret  = (op == OP_RET)  || ((op & OP_GRP_MASK) == OP_GRP_RCC);

  // Classify the transaction and work out taken and cycle count
  always_comb begin
    dec_o            = '0;
    dec_o.kind       = KIND_NONE;
    dec_o.cycles     = CYC_NONE;
    if (item_i.req_type) begin
      dec_o.kind       = KIND_LOAD;
      dec_o.recognized = 1'b1;
    end else if (is_jump) begin
      dec_o.kind       = KIND_JUMP;
      dec_o.recognized = 1'b1;
      dec_o.taken      = (op == OP_JMP) || cond;
      dec_o.cycles     = CYC_JUMP;
    end else if (is_call) begin
      dec_o.kind       = KIND_CALL;
      dec_o.recognized = 1'b1;
      dec_o.taken      = (op == OP_CALL) || cond;
      dec_o.cycles     = dec_o.taken ? CYC_CALL_TKN : CYC_CALL_NTKN;
    end else if (is_ret) begin
      dec_o.kind       = KIND_RET;
      dec_o.recognized = 1'b1;
      dec_o.taken      = (op == OP_RET) || cond;
      if (op == OP_RET) begin
        dec_o.cycles = CYC_RET;
      end else begin
        dec_o.cycles = cond ? CYC_RCC_TKN : CYC_RCC_NTKN;
      end
    end
  end

endmodule

[hw/rtl/bcru_seq.sv]
`include "i8080_branch_call_return_unit_macros.svh"

module bcru_seq #(
  parameter int unsigned ADDR_BITS = bcru_pkg::STACK_ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  bcru_pkg::bcru_in_t   in_item_i,
  input  bcru_pkg::bcru_dec_t  dec_i,
  input  logic                 out_free_i,
  output bcru_pkg::bcru_ctrl_t ctrl_o,
  output logic                 ram_en_o,
  output logic                 ram_we_o,
  output logic [ADDR_BITS-1:0] ram_addr_o,
  output logic [7:0]           ram_wdata_o,
  input  logic [7:0]           ram_rdata_i
);
  import bcru_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_RUN    = 5'b00010,
    ST_PUSH   = 5'b00100,
    ST_POP_LO = 5'b01000,
    ST_POP_HI = 5'b10000
  } seq_state_e;

  seq_state_e           state_q, state_d;
  logic [ADDR_W-1:0]    pc_q, pc_d;
  logic [ADDR_W-1:0]    sp_q, sp_d;
  logic [ADDR_BITS-1:0] clr_q, clr_d;
  logic [7:0]           byte_q, byte_d;
  logic [CYC_W-1:0]     cyc_q, cyc_d;

  logic [ADDR_W-1:0]    pc_plus3;
  logic [ADDR_W-1:0]    pc_plus1;
  logic [ADDR_W-1:0]    sp_minus1;
  logic [ADDR_W-1:0]    target;

  assign pc_plus3  = pc_q + PC_STEP_LONG;
  assign pc_plus1  = pc_q + PC_STEP_SHORT;
  assign sp_minus1 = sp_q - SP_STEP_ONE;
  assign target    = {in_item_i.target_high, in_item_i.target_low};

  // Sequence clearing, pushes and pops through the single memory port
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    sp_d        = sp_q;
    clr_d       = clr_q;
    byte_d      = byte_q;
    cyc_d       = cyc_q;
    ram_en_o    = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = sp_q[ADDR_BITS-1:0];
    ram_wdata_o = '0;
    ctrl_o      = '0;
    ctrl_o.ready = (state_q == ST_RUN);

    case (state_q)
      ST_CLEAR: begin
        ram_en_o   = 1'b1;
        ram_we_o   = 1'b1;
        ram_addr_o = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (in_fire_i) begin
          ctrl_o.done = 1'b1;
          case (dec_i.kind)
            KIND_LOAD: begin
              pc_d = in_item_i.load_pc;
              sp_d = in_item_i.load_sp;
            end
            KIND_JUMP: begin
              pc_d = dec_i.taken ? target : pc_plus3;
            end
            KIND_CALL: begin
              if (dec_i.taken) begin
                ram_en_o    = 1'b1;
                ram_we_o    = 1'b1;
                ram_addr_o  = sp_minus1[ADDR_BITS-1:0];
                ram_wdata_o = pc_plus3[15:8];
                byte_d      = pc_plus3[7:0];
                sp_d        = sp_q - SP_STEP_TWO;
                pc_d        = target;
                state_d     = ST_PUSH;
              end else begin
                pc_d = pc_plus3;
              end
            end
            KIND_RET: begin
              if (dec_i.taken) begin
                ram_en_o    = 1'b1;
                ram_addr_o  = sp_q[ADDR_BITS-1:0];
                sp_d        = sp_q + SP_STEP_TWO;
                cyc_d       = dec_i.cycles;
                ctrl_o.done = 1'b0;
                state_d     = ST_POP_LO;
              end else begin
                pc_d = pc_plus1;
              end
            end
            default: ;
          endcase
          ctrl_o.result.next_pc     = pc_d;
          ctrl_o.result.next_sp     = sp_d;
          ctrl_o.result.taken       = dec_i.taken;
          ctrl_o.result.cycle_count = dec_i.cycles;
          ctrl_o.result.recognized  = dec_i.recognized;
        end
      end
      ST_PUSH: begin
        // Low byte of the return address goes below the high byte
        ram_en_o    = 1'b1;
        ram_we_o    = 1'b1;
        ram_addr_o  = sp_q[ADDR_BITS-1:0];
        ram_wdata_o = byte_q;
        state_d     = ST_RUN;
      end
      ST_POP_LO: begin
        // Capture the low byte, fetch the high byte
        byte_d     = ram_rdata_i;
        ram_en_o   = 1'b1;
        ram_addr_o = sp_minus1[ADDR_BITS-1:0];
        state_d    = ST_POP_HI;
      end
      ST_POP_HI: begin
        // Hold the read data until the result register is free
        if (out_free_i) begin
          pc_d                      = {ram_rdata_i, byte_q};
          ctrl_o.done               = 1'b1;
          ctrl_o.result.next_pc     = pc_d;
          ctrl_o.result.next_sp     = sp_q;
          ctrl_o.result.taken       = 1'b1;
          ctrl_o.result.cycle_count = cyc_q;
          ctrl_o.result.recognized  = 1'b1;
          state_d                   = ST_RUN;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pc_q    <= '0;
      sp_q    <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      sp_q    <= sp_d;
      clr_q   <= clr_d;
    end
  end

  // Data held across the memory steps
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    cyc_q  <= cyc_d;
  end

  `BCRU_ASSERT(a_call_pushes, clk_i, rst_ni, in_fire_i && dec_i.kind == KIND_CALL && dec_i.taken |=> state_q == ST_PUSH, "taken call did not start the second push")
  `BCRU_ASSERT(a_pop_loads_pc, clk_i, rst_ni, state_q == ST_POP_HI && out_free_i |=> pc_q[15:8] == $past(ram_rdata_i) && pc_q[7:0] == $past(byte_q), "popped bytes did not reach the PC")
  `BCRU_ASSERT(a_done_states, clk_i, rst_ni, ctrl_o.done |-> state_q == ST_RUN || state_q == ST_POP_HI, "result issued from a busy state")
  `BCRU_ASSERT_ALWAYS(a_no_fire_busy, clk_i, in_fire_i |-> state_q == ST_RUN, "transaction taken while the sequencer is busy")

endmodule

[hw/rtl/i8080_branch_call_return_unit.sv]
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o  | in_item_i  (bcru_in_t)
// out     | output    | out_valid_o / out_ready_i | out_item_o (bcru_out_t)
//
// Jumps, loads, unknown opcodes and untaken calls or returns are finished as they are accepted.
// A taken call makes two byte writes on the single stack RAM port (run, then push state),
// a taken return two registered byte reads (run, pop-low, then pop-high state).
// After reset the stack RAM is zeroed, one byte per cycle, while in_ready_o stays low.
// A stalled output register holds its transaction and stops new input.
module i8080_branch_call_return_unit #(
  parameter int unsigned STACK_ADDR_BITS = bcru_pkg::STACK_ADDR_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bcru_pkg::bcru_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bcru_pkg::bcru_out_t out_item_o
);
  import bcru_pkg::*;

  localparam int unsigned STACK_DEPTH = 2 ** STACK_ADDR_BITS;

  bcru_dec_t                  dec;
  bcru_ctrl_t                 ctrl;
  logic                       out_free;
  logic                       in_fire;
  logic                       ram_en;
  logic                       ram_we;
  logic [STACK_ADDR_BITS-1:0] ram_addr;
  logic [7:0]                 ram_wdata;
  logic [7:0]                 ram_rdata;
  logic                       out_valid_q;
  bcru_out_t                  out_item_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = ctrl.ready && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  bcru_decode u_decode (
    .item_i (in_item_i),
    .dec_o  (dec)
  );

  bcru_seq #(
    .ADDR_BITS (STACK_ADDR_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_item_i   (in_item_i),
    .dec_i       (dec),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl),
    .ram_en_o    (ram_en),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  bcru_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Output register: load on completion, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      out_item_q <= ctrl.result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import bcru_pkg::*;

  localparam int unsigned STACK_DEPTH  = 1 << STACK_ADDR_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned PRESSURE_AT  = 400;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned REPORT_MAX   = 10;

  // Track PC, SP and stack bytes; hold expected outcomes in arrival order
  class transfer_scoreboard;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] sp;
    logic [7:0]        stack_mem [STACK_DEPTH];
    bcru_out_t         pending_outcomes [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       taken_cnt;
    int unsigned       kind_cnt [5];

    function new();
      pc = '0;
      sp = '0;
      foreach (stack_mem[i]) stack_mem[i] = '0;
      mismatches = 0;
      checked    = 0;
      taken_cnt  = 0;
      foreach (kind_cnt[i]) kind_cnt[i] = 0;
    endfunction

    // Evaluate one of the eight flag conditions selected by opcode bits 5:3
    function bit cond_met(logic [2:0] sel, logic [7:0] flags);
      logic flag;
      case (sel[2:1])
        COND_Z:  flag = flags[6];
        COND_C:  flag = flags[0];
        COND_P:  flag = flags[2];
        default: flag = flags[7];
      endcase
      return sel[0] ? flag : !flag;
    endfunction

    // Advance the copy of the unit by one accepted transaction
    function void note_transaction(bcru_in_t it);
      bcru_out_t  res;
      bcru_kind_e kind;
      logic [7:0] op;
      logic [7:0] lo;
      logic [7:0] hi;
      bit         go;
      op = it.opcode;
      res = '0;
      if (it.req_type)
        kind = KIND_LOAD;
      else if (op == OP_JMP || (op & OP_GRP_MASK) == OP_GRP_JCC)
        kind = KIND_JUMP;
      else if (op == OP_CALL || (op & OP_GRP_MASK) == OP_GRP_CCC)
        kind = KIND_CALL;
      else if (op == OP_RET || (op & OP_GRP_MASK) == OP_GRP_RCC)
        kind = KIND_RET;
      else
        kind = KIND_NONE;
      go = (op == OP_JMP || op == OP_CALL || op == OP_RET) ||
           cond_met(op[5:3], it.flag_byte);
      res.cycle_count = CYC_NONE;
      case (kind)
        KIND_LOAD: begin
          pc = it.load_pc;
          sp = it.load_sp;
        end
        KIND_JUMP: begin
          pc = pc + PC_STEP_LONG;
          if (go) begin
            pc = {it.target_high, it.target_low};
            res.taken = 1'b1;
          end
          res.cycle_count = CYC_JUMP;
        end
        KIND_CALL: begin
          pc = pc + PC_STEP_LONG;
          res.cycle_count = CYC_CALL_NTKN;
          if (go) begin
            // Push the return address, high byte first
            sp = sp - SP_STEP_ONE;
            stack_mem[sp[STACK_ADDR_BITS_DEF-1:0]] = pc[15:8];
            sp = sp - SP_STEP_ONE;
            stack_mem[sp[STACK_ADDR_BITS_DEF-1:0]] = pc[7:0];
            pc = {it.target_high, it.target_low};
            res.taken = 1'b1;
            res.cycle_count = CYC_CALL_TKN;
          end
        end
        KIND_RET: begin
          pc = pc + PC_STEP_SHORT;
          res.cycle_count = CYC_RCC_NTKN;
          if (go) begin
            // Pop low byte then high byte
            lo = stack_mem[sp[STACK_ADDR_BITS_DEF-1:0]];
            sp = sp + SP_STEP_ONE;
            hi = stack_mem[sp[STACK_ADDR_BITS_DEF-1:0]];
            sp = sp + SP_STEP_ONE;
            pc = {hi, lo};
            res.taken = 1'b1;
            res.cycle_count = (op == OP_RET) ? CYC_RET : CYC_RCC_TKN;
          end
        end
        default: ;
      endcase
      res.next_pc    = pc;
      res.next_sp    = sp;
      res.recognized = (kind != KIND_NONE);
      kind_cnt[int'(kind)]++;
      if (res.taken) taken_cnt++;
      pending_outcomes.push_back(res);
    endfunction

    // Compare one output transaction with the oldest outcome waiting
    function void check_outcome(bcru_out_t got);
      bcru_out_t want;
      checked++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected result pc=%h sp=%h taken=%b cyc=%0d rec=%b",
                   got.next_pc, got.next_sp, got.taken, got.cycle_count, got.recognized);
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.next_pc !== want.next_pc || got.next_sp !== want.next_sp ||
          got.taken !== want.taken || got.cycle_count !== want.cycle_count ||
          got.recognized !== want.recognized) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: #%0d exp pc=%h sp=%h t=%b c=%0d r=%b got pc=%h sp=%h t=%b c=%0d r=%b",
                   checked, want.next_pc, want.next_sp, want.taken, want.cycle_count,
                   want.recognized, got.next_pc, got.next_sp, got.taken, got.cycle_count,
                   got.recognized);
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  bcru_in_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  bcru_out_t out_item_o;

  transfer_scoreboard sb = new();
  bit          pressure_req  = 1'b0;
  bit          pressure_done = 1'b0;
  int unsigned cycle_cnt     = 0;

  i8080_branch_call_return_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Free-running clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Record accepted transactions on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_transaction(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_outcome(out_item_o);
    end
  end

  function automatic bcru_in_t make_item(logic req, logic [7:0] op, logic [7:0] tl,
                                         logic [7:0] th, logic [7:0] fl,
                                         logic [15:0] lpc, logic [15:0] lsp);
    bcru_in_t it;
    it.req_type    = req;
    it.opcode      = op;
    it.target_low  = tl;
    it.target_high = th;
    it.flag_byte   = fl;
    it.load_pc     = lpc;
    it.load_sp     = lsp;
    return it;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_item(input bcru_in_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid for a number of cycles
  task automatic idle_input(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Receiver: ready runs broken by short stalls, plus one long hold
  initial begin
    int unsigned hold_len;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (pressure_req && !pressure_done) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        pressure_done = 1'b1;
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      hold_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (hold_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
      end
    end
  end

  // Abort a hung run
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Reset, directed transactions, random bursts, drain and verdict
  initial begin
    bcru_in_t    it;
    int unsigned sent;
    int unsigned burst;
    int unsigned r;
    logic [2:0]  sel;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wrap PC and SP around the top of the address space
    send_item(make_item(1'b1, 8'hFF, 8'h00, 8'h00, 8'h00, 16'hFFFF, 16'h0001));
    send_item(make_item(1'b0, OP_CALL, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_item(make_item(1'b0, OP_JMP, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(1'b0, OP_RET, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000));
    // Walk every condition: flags clear for jumps and returns, set for calls
    for (int c = 0; c < 8; c++)
      send_item(make_item(1'b0, OP_GRP_JCC | 8'(c << 3), 8'(c), 8'hA5, 8'h00,
                          16'h0000, 16'h0000));
    for (int c = 0; c < 8; c++)
      send_item(make_item(1'b0, OP_GRP_CCC | 8'(c << 3), 8'h5A, 8'(c), 8'hFF,
                          16'h0000, 16'h0000));
    for (int c = 0; c < 8; c++)
      send_item(make_item(1'b0, OP_GRP_RCC | 8'(c << 3), 8'h00, 8'h00, 8'h00,
                          16'h0000, 16'h0000));
    // Undocumented aliases change nothing
    send_item(make_item(1'b0, 8'hCB, 8'h12, 8'h34, 8'h00, 16'h0000, 16'h0000));
    send_item(make_item(1'b0, 8'hD9, 8'h12, 8'h34, 8'hFF, 16'h0000, 16'h0000));
    send_item(make_item(1'b0, 8'hDD, 8'h12, 8'h34, 8'h00, 16'h0000, 16'h0000));
    send_item(make_item(1'b0, 8'hED, 8'h12, 8'h34, 8'hFF, 16'h0000, 16'h0000));
    send_item(make_item(1'b0, 8'hFD, 8'h12, 8'h34, 8'h00, 16'h0000, 16'h0000));
    // Load ignores a call opcode
    send_item(make_item(1'b1, OP_CALL, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'hFFFF));

    // Random bursts, mostly control-transfer opcodes with random operands
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        if (sent == PRESSURE_AT) pressure_req = 1'b1;
        r   = $urandom_range(0, 99);
        sel = 3'($urandom);
        it.req_type    = 1'b0;
        it.target_low  = 8'($urandom);
        it.target_high = 8'($urandom);
        it.flag_byte   = 8'($urandom);
        it.load_pc     = 16'($urandom);
        it.load_sp     = 16'($urandom);
        if (r < 30)
          it.opcode = (r < 5) ? OP_JMP : (OP_GRP_JCC | {2'b00, sel, 3'b000});
        else if (r < 55)
          it.opcode = (r < 35) ? OP_CALL : (OP_GRP_CCC | {2'b00, sel, 3'b000});
        else if (r < 80)
          it.opcode = (r < 60) ? OP_RET : (OP_GRP_RCC | {2'b00, sel, 3'b000});
        else if (r < 86) begin
          it.req_type = 1'b1;
          it.opcode   = 8'($urandom);
          case ($urandom_range(0, 4))
            0: it.load_sp = 16'h0000;
            1: it.load_sp = 16'hFFFF;
            2: it.load_sp = 16'h0001;
            default: ;
          endcase
          if ($urandom_range(0, 3) == 0) it.load_pc = 16'hFFFE;
        end else
          it.opcode = 8'($urandom);
        send_item(it);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d jumps, %0d calls, %0d returns, %0d loads, %0d unknown opcodes",
             sb.kind_cnt[int'(KIND_JUMP)], sb.kind_cnt[int'(KIND_CALL)],
             sb.kind_cnt[int'(KIND_RET)], sb.kind_cnt[int'(KIND_LOAD)],
             sb.kind_cnt[int'(KIND_NONE)]);
    $display("%0d transfers taken, %0d results checked, %0d mismatches, %0d-cycle output hold",
             sb.taken_cnt, sb.checked, sb.mismatches, LONG_HOLD);
    if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bcru_pkg.sv
hw/rtl/bcru_ram.sv
hw/rtl/bcru_decode.sv
hw/rtl/bcru_seq.sv
hw/rtl/i8080_branch_call_return_unit.sv
tb/tb_top.sv
